// ----- sv/min_heap_priority_queue_top_assert.svh -----
// ----------------------------------------------------------------------------
// Min-heap priority queue assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define MHPQ_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Whenever the first expression holds, the second holds at the same edge.
`define MHPQ_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

// ----- sv/mhpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Entry, token and write-back types shared by the level cells and the top.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int DATA_W     = 32;
   localparam int OCC_W      = 9;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 80;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] pri;
      logic signed [DATA_W-1:0] dat;
   } entry_type;

   // Work token that travels down the row of level cells.
   typedef struct packed {
      logic                     valid;
      logic                     down;
      logic                     shift;
      logic signed [DATA_W-1:0] key;
      entry_type                carry;
   } token_type;

   // Write from a cell into the level above it.
   typedef struct packed {
      logic      valid;
      entry_type data;
   } wback_type;

   function automatic logic pri_less(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
      return a < b;
   endfunction

endpackage

// ----- sv/mhpq_level_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap level cell
// Holds one level of the heap and processes the work token for that level.
// ----------------------------------------------------------------------------
module mhpq_level_cell
   import mhpq_pkg::*;
#(
   parameter int LEVEL  = 1,
   parameter int LEVELS = 9,
   localparam int PW = LEVELS - 1,
   localparam int CW = LEVELS,
   localparam int LW = $clog2(LEVELS)
) (
   input  logic           clock,
   input  logic           reset,
   input  token_type      up_tok,
   input  logic [PW-1:0]  up_off,
   input  logic [PW-1:0]  up_path,
   input  logic [LW-1:0]  up_tgt,
   input  logic [CW-1:0]  up_cnt,
   output token_type      dn_tok,
   output logic [PW-1:0]  dn_off,
   output logic [PW-1:0]  dn_path,
   output logic [LW-1:0]  dn_tgt,
   output logic [CW-1:0]  dn_cnt,
   input  wback_type      dn_wb,
   input  logic [PW-1:0]  dn_wb_addr,
   output wback_type      up_wb,
   output logic [PW-1:0]  up_wb_addr,
   input  logic [PW-1:0]  rd_off,
   output entry_type      rd_data,
   output logic           done
);

   localparam logic LAST = (LEVEL == LEVELS - 1);

   token_type     tok_ff;
   logic [PW-1:0] off_ff;
   logic [PW-1:0] path_ff;
   logic [LW-1:0] tgt_ff;
   logic [CW-1:0] cnt_ff;
   token_type     dn_tok_ff;
   token_type     dn_tok_in;
   logic [PW-1:0] dn_off_ff;
   logic [PW-1:0] dn_off_in;
   logic [PW-1:0] dn_path_ff;
   logic [LW-1:0] dn_tgt_ff;
   logic [CW-1:0] dn_cnt_ff;
   logic          done_ff;
   logic          done_in;
   entry_type     rd_a_ff;
   entry_type     wr_data;
   logic          wr_en;
   logic          at_tgt;
   logic          ins_take;

   assign at_tgt   = (tgt_ff == LW'(LEVEL));
   assign ins_take = tok_ff.valid && !tok_ff.down &&
                     (at_tgt || tok_ff.shift || pri_less(tok_ff.key, rd_a_ff.pri));

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= '0;
         dn_tok_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         tok_ff    <= up_tok;
         dn_tok_ff <= dn_tok_in;
         done_ff   <= done_in;
      end
      off_ff     <= up_off;
      path_ff    <= up_path;
      tgt_ff     <= up_tgt;
      cnt_ff     <= up_cnt;
      dn_off_ff  <= dn_off_in;
      dn_path_ff <= path_ff << 1;
      dn_tgt_ff  <= tgt_ff;
      dn_cnt_ff  <= cnt_ff;
   end

   generate
      if (LEVEL == 0) begin : g_root
         entry_type root_ff;

         always_ff @(posedge clock) begin
            if (wr_en) begin
               root_ff <= wr_data;
            end
            rd_a_ff <= root_ff;
         end

         always_comb begin
            dn_tok_in  = '0;
            dn_off_in  = off_ff;
            done_in    = 1'b0;
            up_wb      = '0;
            up_wb_addr = '0;
            wr_en      = ins_take;
            wr_data    = tok_ff.carry;
            if (tok_ff.valid && !tok_ff.down) begin
               if (at_tgt) begin
                  done_in = 1'b1;
               end else begin
                  dn_tok_in       = tok_ff;
                  dn_tok_in.shift = ins_take;
                  if (ins_take) begin
                     dn_tok_in.carry = rd_a_ff;
                  end
                  dn_off_in = PW'({off_ff, path_ff[PW-1]});
               end
            end else if (tok_ff.valid) begin
               dn_tok_in = tok_ff;
            end
            if (dn_wb.valid && (dn_wb_addr == '0)) begin
               wr_en   = 1'b1;
               wr_data = dn_wb.data;
            end
         end
      end else begin : g_level
         localparam int DEPTH = 2 ** LEVEL;

         entry_type        mem [DEPTH];
         entry_type        rd_b_ff;
         logic [LEVEL-1:0] rd_a_addr;
         logic [LEVEL-1:0] rd_b_addr;
         logic [LEVEL-1:0] wr_addr;
         logic [LEVEL-1:0] sel_off;
         logic [CW-1:0]    left_idx;
         logic             left_ok;
         logic             pick_b;
         logic             swap;
         entry_type        sel;

         always_comb begin
            rd_a_addr = LEVEL'(rd_off);
            rd_b_addr = LEVEL'({up_off, 1'b1});
            if (up_tok.valid && !up_tok.down) begin
               rd_a_addr = LEVEL'(up_off);
            end else if (up_tok.valid) begin
               rd_a_addr = LEVEL'({up_off, 1'b0});
            end
         end

         always_ff @(posedge clock) begin
            if (wr_en) begin
               mem[wr_addr] <= wr_data;
            end
            rd_a_ff <= mem[rd_a_addr];
            rd_b_ff <= mem[rd_b_addr];
         end

         assign left_idx = CW'(2 ** LEVEL) + CW'({off_ff, 1'b0});
         assign left_ok  = (left_idx <= cnt_ff);
         assign pick_b   = (left_idx < cnt_ff) && pri_less(rd_b_ff.pri, rd_a_ff.pri);
         assign sel      = pick_b ? rd_b_ff : rd_a_ff;
         assign sel_off  = LEVEL'({off_ff, pick_b});
         assign swap     = left_ok && pri_less(sel.pri, tok_ff.carry.pri);

         always_comb begin
            dn_tok_in  = '0;
            dn_off_in  = '0;
            done_in    = 1'b0;
            up_wb      = '0;
            up_wb_addr = off_ff;
            wr_en      = 1'b0;
            wr_addr    = LEVEL'(off_ff);
            wr_data    = tok_ff.carry;
            if (tok_ff.valid && !tok_ff.down) begin
               wr_en = ins_take;
               if (at_tgt) begin
                  done_in = 1'b1;
               end else begin
                  dn_tok_in       = tok_ff;
                  dn_tok_in.shift = ins_take;
                  if (ins_take) begin
                     dn_tok_in.carry = rd_a_ff;
                  end
                  dn_off_in = PW'({off_ff, path_ff[PW-1]});
               end
            end else if (tok_ff.valid) begin
               up_wb.valid = 1'b1;
               up_wb.data  = swap ? sel : tok_ff.carry;
               if (swap && !LAST) begin
                  dn_tok_in = tok_ff;
                  dn_off_in = PW'(sel_off);
               end else begin
                  done_in = 1'b1;
               end
               if (swap && LAST) begin
                  wr_en   = 1'b1;
                  wr_addr = sel_off;
               end
            end
            if (dn_wb.valid) begin
               wr_en   = 1'b1;
               wr_addr = LEVEL'(dn_wb_addr);
               wr_data = dn_wb.data;
            end
         end
      end
   endgenerate

   assign dn_tok  = dn_tok_ff;
   assign dn_off  = dn_off_ff;
   assign dn_path = dn_path_ff;
   assign dn_tgt  = dn_tgt_ff;
   assign dn_cnt  = dn_cnt_ff;
   assign rd_data = rd_a_ff;
   assign done    = done_ff;

endmodule

// ----- sv/min_heap_priority_queue_top.sv -----
`timescale 1ns / 1ps
// A binary min-heap priority queue of CAPACITY entries, each a signed 32-bit
// priority with a 32-bit data word. The heap is held as a row of level cells,
// one per tree level, each owning the store of its level; a work token walks
// down the row, and in each cell a registered read comes first, then the
// compare and write. An insert always walks down to the level of the new
// last slot before its result is loaded. A remove first fetches the root and
// the last entry in its fetch and load states, then walks the moved entry down
// until it settles; a remove that empties the queue loads its result without
// a walk, and insert into a full queue or remove from an empty one goes
// straight to loading its error status. One transaction is worked at a time
// and the next is accepted in the cycle after the result is loaded; the result
// register lets that happen while an earlier result waits, and a second
// finished result holds the sequencer until the first one is taken.
// ----------------------------------------------------------------------------
// Min-heap priority queue top level
// Stream front end, command sequencer and the row of heap level cells.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] entry_priority, [63:32] entry_data
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] out_priority, [63:32] out_data, [72:64] occupancy, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [STATUS_W-1:0]   rsp_tuser
);

`include "min_heap_priority_queue_top_assert.svh"

   localparam int LEVELS = $clog2(CAPACITY + 1);
   localparam int PW     = LEVELS - 1;
   localparam int CW     = LEVELS;
   localparam int LW     = $clog2(LEVELS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_BUSY,
      ST_REPLY
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         count_ff;
   token_type             tok0_ff;
   logic [PW-1:0]         path0_ff;
   logic [LW-1:0]         tgt0_ff;
   logic [CW-1:0]         cnt0_ff;
   logic [PW-1:0]         rd_off_ff;
   logic [LW-1:0]         rd_lvl_ff;
   logic [STATUS_W-1:0]   res_status_ff;
   logic [DATA_W-1:0]     res_pri_ff;
   logic [DATA_W-1:0]     res_dat_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_user_ff;
   logic                  tok0_valid_in;
   logic                  rsp_valid_in;
   logic                  reply_go;

   token_type     tok_bus     [LEVELS+1];
   logic [PW-1:0] off_bus     [LEVELS+1];
   logic [PW-1:0] path_bus    [LEVELS+1];
   logic [LW-1:0] tgt_bus     [LEVELS+1];
   logic [CW-1:0] cnt_bus     [LEVELS+1];
   wback_type     wb_bus      [LEVELS+1];
   logic [PW-1:0] wb_addr_bus [LEVELS+1];
   entry_type     rd_bus      [LEVELS];
   logic [LEVELS-1:0] done_vec;
   logic [LEVELS:0]   tok_vld_vec;

   logic [CW-1:0] node_idx;
   logic [LW-1:0] node_lvl;
   logic [CW-1:0] node_norm;
   entry_type     req_entry;
   logic          req_cmd;

   assign req_cmd       = req_tuser[0];
   assign req_entry.pri = req_tdata[DATA_W-1:0];
   assign req_entry.dat = req_tdata[2*DATA_W-1:DATA_W];

   // Heap position (counted from one) of the slot that the command touches.
   assign node_idx = (req_cmd == CMD_REMOVE) ? count_ff : count_ff + CW'(1);

   always_comb begin
      node_lvl = '0;
      for (int i = 0; i < CW; i++) begin
         if (node_idx[i]) begin
            node_lvl = LW'(i);
         end
      end
   end

   assign node_norm = node_idx << (LW'(PW) - node_lvl);

   assign reply_go      = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in  = reply_go || (rsp_valid_ff && !rsp_tready);
   assign tok0_valid_in = ((state_ff == ST_IDLE) && req_tvalid && (req_cmd == CMD_INSERT) &&
                           (count_ff != CW'(CAPACITY))) ||
                          ((state_ff == ST_LOAD) && (count_ff != CW'(1)));

   assign tok_bus[0]         = tok0_ff;
   assign off_bus[0]         = '0;
   assign path_bus[0]        = path0_ff;
   assign tgt_bus[0]         = tgt0_ff;
   assign cnt_bus[0]         = cnt0_ff;
   assign wb_bus[LEVELS]     = '0;
   assign wb_addr_bus[LEVELS] = '0;

   generate
      for (genvar l = 0; l < LEVELS; l++) begin : g_cell
         mhpq_level_cell #(
            .LEVEL  (l),
            .LEVELS (LEVELS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .up_tok     (tok_bus[l]),
            .up_off     (off_bus[l]),
            .up_path    (path_bus[l]),
            .up_tgt     (tgt_bus[l]),
            .up_cnt     (cnt_bus[l]),
            .dn_tok     (tok_bus[l+1]),
            .dn_off     (off_bus[l+1]),
            .dn_path    (path_bus[l+1]),
            .dn_tgt     (tgt_bus[l+1]),
            .dn_cnt     (cnt_bus[l+1]),
            .dn_wb      (wb_bus[l+1]),
            .dn_wb_addr (wb_addr_bus[l+1]),
            .up_wb      (wb_bus[l]),
            .up_wb_addr (wb_addr_bus[l]),
            .rd_off     (rd_off_ff),
            .rd_data    (rd_bus[l]),
            .done       (done_vec[l])
         );
      end
      for (genvar t = 0; t <= LEVELS; t++) begin : g_tok_vld
         assign tok_vld_vec[t] = tok_bus[t].valid;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tok0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tok0_ff.valid <= tok0_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  res_pri_ff    <= '0;
                  res_dat_ff    <= '0;
                  res_status_ff <= STATUS_DONE;
                  rd_off_ff     <= PW'(node_idx);
                  rd_lvl_ff     <= node_lvl;
                  if (req_cmd == CMD_INSERT) begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_status_ff <= STATUS_FULL;
                        state_ff      <= ST_REPLY;
                     end else begin
                        tok0_ff.down  <= 1'b0;
                        tok0_ff.shift <= 1'b0;
                        tok0_ff.key   <= req_entry.pri;
                        tok0_ff.carry <= req_entry;
                        path0_ff      <= node_norm[PW-1:0];
                        tgt0_ff       <= node_lvl;
                        cnt0_ff       <= count_ff + CW'(1);
                        count_ff      <= count_ff + CW'(1);
                        state_ff      <= ST_BUSY;
                     end
                  end else begin
                     if (count_ff == '0) begin
                        res_status_ff <= STATUS_EMPTY;
                        state_ff      <= ST_REPLY;
                     end else begin
                        state_ff <= ST_FETCH;
                     end
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               res_pri_ff <= rd_bus[0].pri;
               res_dat_ff <= rd_bus[0].dat;
               count_ff   <= count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_ff <= ST_REPLY;
               end else begin
                  tok0_ff.down  <= 1'b1;
                  tok0_ff.shift <= 1'b0;
                  tok0_ff.key   <= '0;
                  tok0_ff.carry <= rd_bus[rd_lvl_ff];
                  path0_ff      <= '0;
                  tgt0_ff       <= '0;
                  cnt0_ff       <= count_ff - CW'(1);
                  state_ff      <= ST_BUSY;
               end
            end
            ST_BUSY: begin
               if (|done_vec) begin
                  state_ff <= ST_REPLY;
               end
            end
            ST_REPLY: begin
               if (reply_go) begin
                  rsp_user_ff  <= res_status_ff;
                  rsp_data_ff  <= RSP_DATA_W'({OCC_W'(count_ff), res_dat_ff, res_pri_ff});
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `MHPQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(CAPACITY), "entry count above capacity")
   `MHPQ_ASSERT_IMPLIES(a_done_busy, |done_vec, state_ff == ST_BUSY, "cell finished while not busy")
   `MHPQ_ASSERT_ALWAYS(a_one_done, $onehot0(done_vec), "more than one cell finished")
   `MHPQ_ASSERT_ALWAYS(a_one_token, $onehot0(tok_vld_vec), "more than one token in the row")

endmodule

// ----- verif/tb_min_heap_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue testbench
// Sends insert and remove transactions with random idle gaps on both streams.
// A shadow heap predicts each result, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_top;
   import mhpq_pkg::*;

   localparam int CAPACITY     = 256;
   localparam int TOTAL_ITEMS  = 1150;
   localparam int MAX_GAP      = 18;
   localparam int SETTLE_TICKS = 40;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   pri;
      logic [DATA_W-1:0]   dat;
      logic [OCC_W-1:0]    occupancy;
   } heap_result_type;

   class heap_tracker;
      entry_type       shadow_heap[CAPACITY];
      int unsigned     shadow_count;
      heap_result_type awaited_results[$];
      int              errors;

      function new();
         shadow_count = 0;
         errors = 0;
      endfunction

      task report(input string what);
         $display("%0t ns: mismatch: %s", $time, what);
         errors++;
      endtask

      // Applies one accepted command to the shadow heap and queues its result.
      function void note_command(input logic cmd, input logic signed [DATA_W-1:0] new_pri,
                                 input logic signed [DATA_W-1:0] new_dat);
         heap_result_type res;
         entry_type       moved;
         int unsigned     cur;
         int unsigned     par;
         int unsigned     left;
         int unsigned     sel;
         res.status = STATUS_DONE;
         res.pri = '0;
         res.dat = '0;
         if (cmd == CMD_INSERT) begin
            if (shadow_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               cur = shadow_count;
               shadow_heap[cur].pri = new_pri;
               shadow_heap[cur].dat = new_dat;
               while (cur > 0) begin
                  par = (cur - 1) / 2;
                  if (!(shadow_heap[cur].pri < shadow_heap[par].pri)) break;
                  moved = shadow_heap[cur];
                  shadow_heap[cur] = shadow_heap[par];
                  shadow_heap[par] = moved;
                  cur = par;
               end
               shadow_count++;
            end
         end else if (shadow_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.pri = shadow_heap[0].pri;
            res.dat = shadow_heap[0].dat;
            shadow_count--;
            shadow_heap[0] = shadow_heap[shadow_count];
            par = 0;
            forever begin
               left = 2 * par + 1;
               if (left >= shadow_count) break;
               sel = left;
               if (left + 1 < shadow_count &&
                   shadow_heap[left + 1].pri < shadow_heap[left].pri) sel = left + 1;
               if (!(shadow_heap[sel].pri < shadow_heap[par].pri)) break;
               moved = shadow_heap[par];
               shadow_heap[par] = shadow_heap[sel];
               shadow_heap[sel] = moved;
               par = sel;
            end
         end
         res.occupancy = shadow_count[OCC_W-1:0];
         awaited_results.push_back(res);
      endfunction

      task check_result(input logic [STATUS_W-1:0] status,
                        input logic [RSP_DATA_W-1:0] payload);
         heap_result_type want;
         if (awaited_results.size() == 0) begin
            report("result transaction with nothing expected");
            return;
         end
         want = awaited_results.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
         if (payload[31:0] !== want.pri)
            report($sformatf("out_priority %h, expected %h", payload[31:0], want.pri));
         if (payload[63:32] !== want.dat)
            report($sformatf("out_data %h, expected %h", payload[63:32], want.dat));
         if (payload[72:64] !== want.occupancy)
            report($sformatf("occupancy %0d, expected %0d", payload[72:64], want.occupancy));
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   heap_tracker tracker = new();
   int          send_calm = 0;
   int          recv_calm = 0;

   min_heap_priority_queue_top #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [DATA_W-1:0] draw_priority();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6: return $urandom_range(0, 7);
         7: return $urandom_range(0, 7) - 4;
         8: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return 32'h8000_0000 + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic send_command(input logic cmd, input logic [DATA_W-1:0] pri,
                               input logic [DATA_W-1:0] dat);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {dat, pri};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_command(cmd, pri, dat);
   endtask

   initial begin
      int   gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(recv_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         tracker.check_result(rsp_tuser, rsp_tdata);
      end
   end

   initial begin
      int   sent;
      int   full_hits;
      int   empty_hits;
      logic cmd;
      sent = 0;
      full_hits = 0;
      empty_hits = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Removal from an empty queue, extreme keys and payloads, and equal keys.
      send_command(CMD_REMOVE, $urandom, $urandom);
      send_command(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
      send_command(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
      send_command(CMD_INSERT, 32'h0000_0000, 32'h8000_0000);
      send_command(CMD_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
      send_command(CMD_INSERT, 32'd5, 32'd1);
      send_command(CMD_INSERT, 32'd5, 32'd2);
      send_command(CMD_INSERT, 32'd5, 32'd3);
      send_command(CMD_INSERT, 32'd1, 32'h5555_5555);
      send_command(CMD_INSERT, 32'h8000_0000, 32'haaaa_aaaa);
      send_command(CMD_REMOVE, $urandom, $urandom);
      send_command(CMD_INSERT, 32'd5, 32'd4);
      repeat (10) send_command(CMD_REMOVE, $urandom, $urandom);

      // Fill past capacity, then drain past empty, then a random walk.
      while (full_hits < 4) begin
         cmd = ($urandom_range(0, 9) == 0) ? CMD_REMOVE : CMD_INSERT;
         if (cmd == CMD_INSERT && tracker.shadow_count >= CAPACITY) full_hits++;
         send_command(cmd, draw_priority(), $urandom);
         sent++;
      end
      while (empty_hits < 3) begin
         cmd = ($urandom_range(0, 9) == 0) ? CMD_INSERT : CMD_REMOVE;
         if (cmd == CMD_REMOVE && tracker.shadow_count == 0) empty_hits++;
         send_command(cmd, draw_priority(), $urandom);
         sent++;
      end
      while (sent < TOTAL_ITEMS) begin
         cmd = ($urandom_range(0, 99) < 53) ? CMD_INSERT : CMD_REMOVE;
         send_command(cmd, draw_priority(), $urandom);
         sent++;
      end
      req_tvalid <= 1'b0;

      while (tracker.awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
         $display("** min_heap_priority_queue_top: PASSED **");
      end else begin
         $display("** min_heap_priority_queue_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("** min_heap_priority_queue_top: FAILED **");
      $finish;
   end

endmodule
